// ===== src/dtr_pkg.sv =====
// ----------------------------------------------------------------------------
// dtr_pkg: shared types and constants for the dirty tile run rectangle unit
// Holds field widths, register indexes, reset values and the state enums
// used by the front, back and divider blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dtr_pkg;

    // Mask word geometry
    localparam int WORD_BITS = 64;
    localparam int BIT_IDX_W = $clog2(WORD_BITS);

    // Tile coordinate width and saturation value
    localparam int DIM_BITS = 14;
    localparam int DIM_MAX  = (1 << DIM_BITS) - 1;

    // Register and field widths
    localparam int FW_W   = 14;
    localparam int FH_W   = 14;
    localparam int TS_W   = 11;
    localparam int X_W    = 14;
    localparam int PIX_W  = 15;
    localparam int MUL_A_W = DIM_BITS + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE    = 2'd2;

    localparam logic [FW_W-1:0] FW_RESET = 14'd1024;
    localparam logic [FH_W-1:0] FH_RESET = 14'd768;
    localparam logic [TS_W-1:0] TS_RESET = 11'd32;

    // Tile count divider: numerator is pixels + tile - 1
    localparam int DIV_NUM_W  = 15;
    localparam int DIV_STEPS  = DIV_NUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    // Word queue between front and back (power of two depth)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Tile count sequencer
    typedef enum logic [2:0] {
        CNT_START_X,
        CNT_WAIT_X,
        CNT_START_Y,
        CNT_WAIT_Y,
        CNT_READY
    } cnt_state_t;

    // Bit scanner
    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_BITS,
        SCAN_CLOSE,
        SCAN_FINISH
    } scan_state_t;

    // Rectangle arithmetic steps on the shared multiplier
    typedef enum logic [1:0] {
        MUL_X,
        MUL_W,
        MUL_Y,
        MUL_OUT
    } mul_step_t;

    // Frame geometry handed from front to back
    typedef struct packed {
        logic                ready;
        logic [TS_W-1:0]     ts;
        logic [FH_W-1:0]     fh;
        logic [DIM_BITS-1:0] tx;
        logic [DIM_BITS-1:0] ty;
    } tile_cfg_t;

    // One closed run, in tile units
    typedef struct packed {
        logic [DIM_BITS-1:0] start_col;
        logic [DIM_BITS:0]   end_col;
        logic [DIM_BITS-1:0] row;
    } run_ev_t;

endpackage

`default_nettype wire

// ===== src/dirty_tile_run_rectangles_unit.sv =====
// ----------------------------------------------------------------------------
// dirty_tile_run_rectangles_unit: dirty tile bitmap to run rectangles
// Scans a row-major dirty tile bitmap word by word and emits one pixel
// rectangle per horizontal run of dirty tiles within a tile row.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_we               cfg_index, cfg_data
//   in       in         in_valid / in_stall  mask_word, last_word
//   out      out        out_valid / out_stall rect_x, rect_y, rect_width,
//                                             rect_height, last_of_word
//
// The scanner walks each word one flag per cycle, except while a new run
// event waits for the busy multiplier behind a held one; each rectangle
// then passes the shared multiplier steps x, width, y and out, and the next
// rectangle enters them only after the last one has left.
// After reset and after every configuration write the tile counts are
// rebuilt by the serial divider; words queue meanwhile.
// The two-word input queue and the output register let either side stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dirty_tile_run_rectangles_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [dtr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dtr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [dtr_pkg::WORD_BITS-1:0]  mask_word,
    input  wire logic                          last_word,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [dtr_pkg::X_W-1:0]             rect_x,
    output logic signed [dtr_pkg::PIX_W-1:0]    rect_y,
    output logic [dtr_pkg::PIX_W-1:0]           rect_width,
    output logic [dtr_pkg::TS_W-1:0]            rect_height,
    output logic                               last_of_word
);
    import dtr_pkg::*;

    logic                 q_valid, q_pop, q_last;
    logic [WORD_BITS-1:0] q_word;
    tile_cfg_t            tile_cfg;

    // Front: config, tile counts, word queue
    dtr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mask_word (mask_word),
        .last_word (last_word),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_word    (q_word),
        .q_last    (q_last),
        .tile_cfg  (tile_cfg)
    );

    // Back: scanner and rectangle arithmetic
    dtr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_word       (q_word),
        .q_last       (q_last),
        .tile_cfg     (tile_cfg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .rect_x       (rect_x),
        .rect_y       (rect_y),
        .rect_width   (rect_width),
        .rect_height  (rect_height),
        .last_of_word (last_of_word)
    );

`ifndef ASSERT_OFF
    // scanner only takes words that are there
    a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("word popped from empty queue");

    // scanner never starts a word on stale tile counts
    a_pop_needs_counts: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> tile_cfg.ready)
        else $error("word started before tile counts were ready");

    // a register write invalidates the tile counts
    a_write_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !tile_cfg.ready)
        else $error("tile counts still marked ready after a write");
`endif

endmodule

`default_nettype wire

// ===== src/dtr_div.sv =====
// ----------------------------------------------------------------------------
// dtr_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, for the tile counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtr_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [dtr_pkg::DIV_NUM_W-1:0] num,
    input  wire logic [dtr_pkg::TS_W-1:0]      den,
    output logic                             busy,
    output logic [dtr_pkg::DIV_NUM_W-1:0]      quot
);
    import dtr_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_NUM_W-1:0] quot_reg, quot_next;
    logic [TS_W-1:0]      rem_reg, rem_next;
    logic [TS_W:0]        rem_sh;

    // One restoring step per cycle
    always_comb
    begin
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        rem_sh    = {rem_reg, num_reg[DIV_NUM_W-1]};
        if (start)
        begin
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            num_next  = num;
            quot_next = '0;
            rem_next  = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            num_next = {num_reg[DIV_NUM_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, den})
            begin
                rem_next  = TS_W'(rem_sh - {1'b0, den});
                quot_next = {quot_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = TS_W'(rem_sh);
                quot_next = {quot_reg[DIV_NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ===== src/dtr_front.sv =====
// ----------------------------------------------------------------------------
// dtr_front: input side of the dirty tile run rectangle unit
// Holds the configuration registers, derives the tile counts with the
// divider and buffers incoming mask words in a short queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtr_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration writes
    input  wire logic                          cfg_we,
    input  wire logic [dtr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dtr_pkg::CFG_DATA_W-1:0] cfg_data,
    // mask words in
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [dtr_pkg::WORD_BITS-1:0]  mask_word,
    input  wire logic                          last_word,
    // queued words out to the scanner
    output logic                               q_valid,
    input  wire logic                          q_pop,
    output logic [dtr_pkg::WORD_BITS-1:0]       q_word,
    output logic                               q_last,
    output dtr_pkg::tile_cfg_t                  tile_cfg
);
    import dtr_pkg::*;

    // Configuration registers
    logic [FW_W-1:0] fw_reg;
    logic [FH_W-1:0] fh_reg;
    logic [TS_W-1:0] ts_reg;
    logic [TS_W-1:0] ts_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FW_RESET;
            fh_reg <= FH_RESET;
            ts_reg <= TS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  fw_reg <= FW_W'(cfg_data);
                CFG_FRAME_HEIGHT: fh_reg <= FH_W'(cfg_data);
                CFG_TILE_SIZE:    ts_reg <= TS_W'(cfg_data);
                default:          ;
            endcase
        end
    end

    // A zero tile size acts as one
    assign ts_eff = (ts_reg == '0) ? TS_W'(1) : ts_reg;

    // Tile count sequencer: ceil(width / tile), then ceil(height / tile)
    cnt_state_t           cnt_state_reg, cnt_state_next;
    logic                 div_start, div_busy;
    logic                 latch_x, latch_y;
    logic [DIV_NUM_W-1:0] div_num, div_quot, num_x, num_y, quot_sat;
    logic [DIM_BITS-1:0]  tx_reg, ty_reg;

    assign num_x = DIV_NUM_W'(fw_reg) + DIV_NUM_W'(ts_eff) - DIV_NUM_W'(1);
    assign num_y = DIV_NUM_W'(fh_reg) + DIV_NUM_W'(ts_eff) - DIV_NUM_W'(1);
    assign div_num = (cnt_state_reg == CNT_START_X) ? num_x : num_y;
    assign quot_sat = (div_quot > DIV_NUM_W'(DIM_MAX)) ? DIV_NUM_W'(DIM_MAX) : div_quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_state_reg <= CNT_START_X;
        else
            cnt_state_reg <= cnt_state_next;
    end

    always_comb
    begin
        cnt_state_next = cnt_state_reg;
        div_start      = 1'b0;
        latch_x        = 1'b0;
        latch_y        = 1'b0;
        case (cnt_state_reg)
            CNT_START_X:
            begin
                div_start      = 1'b1;
                cnt_state_next = CNT_WAIT_X;
            end
            CNT_WAIT_X:
            begin
                if (!div_busy)
                begin
                    latch_x        = 1'b1;
                    cnt_state_next = CNT_START_Y;
                end
            end
            CNT_START_Y:
            begin
                div_start      = 1'b1;
                cnt_state_next = CNT_WAIT_Y;
            end
            CNT_WAIT_Y:
            begin
                if (!div_busy)
                begin
                    latch_y        = 1'b1;
                    cnt_state_next = CNT_READY;
                end
            end
            CNT_READY: ;
            default:   cnt_state_next = CNT_START_X;
        endcase
        // any write restarts the count
        if (cfg_we)
            cnt_state_next = CNT_START_X;
    end

    always_ff @(posedge clk)
    begin
        if (latch_x)
            tx_reg <= DIM_BITS'(quot_sat);
        if (latch_y)
            ty_reg <= DIM_BITS'(quot_sat);
    end

    dtr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (ts_eff),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    assign tile_cfg.ready = (cnt_state_reg == CNT_READY);
    assign tile_cfg.ts    = ts_eff;
    assign tile_cfg.fh    = fh_reg;
    assign tile_cfg.tx    = tx_reg;
    assign tile_cfg.ty    = ty_reg;

    // Word queue
    logic [WORD_BITS-1:0] qw_reg [QUEUE_DEPTH];
    logic                 ql_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]    count_reg;
    logic                 q_push;

    assign in_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_push   = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_word   = qw_reg[rd_ptr_reg];
    assign q_last   = ql_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (q_push && !q_pop)
                count_reg <= count_reg + 1'b1;
            else if (!q_push && q_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            qw_reg[wr_ptr_reg] <= mask_word;
            ql_reg[wr_ptr_reg] <= last_word;
        end
    end

endmodule

`default_nettype wire

// ===== src/dtr_back.sv =====
// ----------------------------------------------------------------------------
// dtr_back: run scanner and rectangle builder
// Walks each mask word one flag per cycle unless an event waits, closes runs
// into events, turns each into pixel coordinates on one shared multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtr_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // queued words
    input  wire logic                         q_valid,
    output logic                              q_pop,
    input  wire logic [dtr_pkg::WORD_BITS-1:0] q_word,
    input  wire logic                         q_last,
    input  wire dtr_pkg::tile_cfg_t            tile_cfg,
    // rectangles out
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [dtr_pkg::X_W-1:0]            rect_x,
    output logic signed [dtr_pkg::PIX_W-1:0]   rect_y,
    output logic [dtr_pkg::PIX_W-1:0]          rect_width,
    output logic [dtr_pkg::TS_W-1:0]           rect_height,
    output logic                              last_of_word
);
    import dtr_pkg::*;

    // Scanner state
    scan_state_t          state_reg, state_next;
    logic [BIT_IDX_W-1:0] bit_idx_reg, bit_idx_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic                 last_reg, last_next;
    logic [DIM_BITS-1:0]  col_reg, col_next;
    logic [DIM_BITS-1:0]  row_reg, row_next;
    logic [DIM_BITS-1:0]  start_reg, start_next;
    logic                 open_reg, open_next;
    logic                 done_reg, done_next;

    // Event held back until it is known whether it is the last of its word
    logic                 pend_valid_reg, pend_valid_next;
    run_ev_t              pend_reg, pend_next;

    // Multiplier stage
    logic                 mq_busy_reg, mq_busy_next;
    mul_step_t            mstep_reg, mstep_next;
    run_ev_t              mq_reg, mq_next;
    logic                 mq_last_reg, mq_last_next;
    logic [PIX_W-1:0]     prod_reg, prod_next;
    logic [X_W-1:0]       x_reg, x_next;
    logic [PIX_W-1:0]     w_reg, w_next;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_A_W+TS_W-1:0] mul_full;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [X_W-1:0]       ox_reg, ox_next;
    logic [PIX_W-1:0]     oy_reg, oy_next;
    logic [PIX_W-1:0]     ow_reg, ow_next;
    logic [TS_W-1:0]      oh_reg, oh_next;
    logic                 ol_reg, ol_next;

    // Per-flag decode
    logic                 bit_set, skip, row_end, ev_fire, hold;
    logic [DIM_BITS:0]    col_inc;
    logic [DIM_BITS-1:0]  row_inc;
    run_ev_t              ev;
    logic                 out_free, out_load;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        // defaults: hold everything
        state_next      = state_reg;
        bit_idx_next    = bit_idx_reg;
        word_next       = word_reg;
        last_next       = last_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        start_next      = start_reg;
        open_next       = open_reg;
        done_next       = done_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        mq_busy_next    = mq_busy_reg;
        mstep_next      = mstep_reg;
        mq_next         = mq_reg;
        mq_last_next    = mq_last_reg;
        prod_next       = prod_reg;
        x_next          = x_reg;
        w_next          = w_reg;
        out_valid_next  = out_valid_reg;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        ow_next         = ow_reg;
        oh_next         = oh_reg;
        ol_next         = ol_reg;
        q_pop           = 1'b0;
        out_load        = 1'b0;

        bit_set = word_reg[bit_idx_reg];
        skip    = done_reg || (tile_cfg.tx == '0) || (tile_cfg.ty == '0)
                  || (row_reg >= tile_cfg.ty);
        col_inc = {1'b0, col_reg} + (DIM_BITS+1)'(1);
        row_inc = row_reg + DIM_BITS'(1);
        row_end = (col_inc >= {1'b0, tile_cfg.tx});
        ev_fire = 1'b0;
        ev.start_col = open_reg ? start_reg : col_reg;
        ev.end_col   = {1'b0, col_reg};
        ev.row       = row_reg;

        // output transfer
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        // multiplier: x, width, then y, one product per cycle
        mul_a = '0;
        case (mstep_reg)
            MUL_X:   mul_a = {1'b0, mq_reg.start_col};
            MUL_W:   mul_a = mq_reg.end_col - {1'b0, mq_reg.start_col};
            MUL_Y:   mul_a = {1'b0, mq_reg.row} + MUL_A_W'(1);
            default: mul_a = '0;
        endcase
        mul_full = mul_a * tile_cfg.ts;

        if (mq_busy_reg)
        begin
            case (mstep_reg)
                MUL_X:
                begin
                    prod_next  = PIX_W'(mul_full);
                    mstep_next = MUL_W;
                end
                MUL_W:
                begin
                    x_next     = X_W'(prod_reg);
                    prod_next  = PIX_W'(mul_full);
                    mstep_next = MUL_Y;
                end
                MUL_Y:
                begin
                    w_next     = prod_reg;
                    prod_next  = PIX_W'(mul_full);
                    mstep_next = MUL_OUT;
                end
                MUL_OUT:
                begin
                    if (out_free)
                    begin
                        out_load     = 1'b1;
                        mq_busy_next = 1'b0;
                    end
                end
                default: mstep_next = MUL_X;
            endcase
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            ox_next        = x_reg;
            ow_next        = w_reg;
            oy_next        = PIX_W'(tile_cfg.fh) - prod_reg;
            oh_next        = tile_cfg.ts;
            ol_next        = mq_last_reg;
        end

        // scanner
        hold = 1'b0;
        case (state_reg)
            SCAN_IDLE:
            begin
                if (q_valid && tile_cfg.ready)
                begin
                    q_pop        = 1'b1;
                    word_next    = q_word;
                    last_next    = q_last;
                    bit_idx_next = '0;
                    state_next   = SCAN_BITS;
                end
            end
            SCAN_BITS:
            begin
                if (!skip)
                begin
                    if (bit_set)
                    begin
                        if (row_end)
                        begin
                            ev_fire     = 1'b1;
                            ev.end_col  = col_inc;
                        end
                    end
                    else if (open_reg)
                        ev_fire = 1'b1;
                end
                hold = ev_fire && pend_valid_reg && mq_busy_reg;
                if (!hold)
                begin
                    if (!skip)
                    begin
                        if (bit_set && !open_reg)
                            start_next = col_reg;
                        open_next = bit_set && !row_end;
                        if (row_end)
                        begin
                            col_next = '0;
                            row_next = row_inc;
                            if (row_inc >= tile_cfg.ty)
                                done_next = 1'b1;
                        end
                        else
                            col_next = DIM_BITS'(col_inc);
                    end
                    bit_idx_next = bit_idx_reg + 1'b1;
                    if (bit_idx_reg == BIT_IDX_W'(WORD_BITS - 1))
                        state_next = SCAN_CLOSE;
                end
            end
            SCAN_CLOSE:
            begin
                // the last word of a frame closes any open run and rewinds
                if (last_reg)
                begin
                    ev_fire = open_reg;
                    hold    = ev_fire && pend_valid_reg && mq_busy_reg;
                    if (!hold)
                    begin
                        col_next   = '0;
                        row_next   = '0;
                        open_next  = 1'b0;
                        start_next = '0;
                        done_next  = 1'b0;
                        state_next = SCAN_FINISH;
                    end
                end
                else
                    state_next = SCAN_FINISH;
            end
            SCAN_FINISH:
            begin
                // the held event is the last one of this word
                if (!pend_valid_reg)
                    state_next = SCAN_IDLE;
                else if (!mq_busy_reg)
                begin
                    mq_busy_next    = 1'b1;
                    mstep_next      = MUL_X;
                    mq_next         = pend_reg;
                    mq_last_next    = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = SCAN_IDLE;
                end
            end
            default: state_next = SCAN_IDLE;
        endcase

        // new event: older held one goes to the multiplier
        if (ev_fire && !hold)
        begin
            if (pend_valid_reg)
            begin
                mq_busy_next = 1'b1;
                mstep_next   = MUL_X;
                mq_next      = pend_reg;
                mq_last_next = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = ev;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SCAN_IDLE;
            col_reg        <= '0;
            row_reg        <= '0;
            start_reg      <= '0;
            open_reg       <= 1'b0;
            done_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            mq_busy_reg    <= 1'b0;
            mstep_reg      <= MUL_X;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            start_reg      <= start_next;
            open_reg       <= open_next;
            done_reg       <= done_next;
            pend_valid_reg <= pend_valid_next;
            mq_busy_reg    <= mq_busy_next;
            mstep_reg      <= mstep_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bit_idx_reg <= bit_idx_next;
        word_reg    <= word_next;
        last_reg    <= last_next;
        pend_reg    <= pend_next;
        mq_reg      <= mq_next;
        mq_last_reg <= mq_last_next;
        prod_reg    <= prod_next;
        x_reg       <= x_next;
        w_reg       <= w_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        ow_reg      <= ow_next;
        oh_reg      <= oh_next;
        ol_reg      <= ol_next;
    end

    assign out_valid    = out_valid_reg;
    assign rect_x       = ox_reg;
    assign rect_y       = $signed(oy_reg);
    assign rect_width   = ow_reg;
    assign rect_height  = oh_reg;
    assign last_of_word = ol_reg;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: dirty tile run rectangle unit
// Feeds mask words through the valid/stall input channel while a built-in
// scanner predicts the rectangles of every transfer. Each output transfer is
// checked field by field against the oldest prediction. Directed cases cover
// the reset geometry, register extremes, the end of a frame and a geometry
// change inside a frame; random frames follow, under random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import dtr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int RANDOM_WORDS = 180;
    localparam int SETTLE_CYCLES = 400;   // three queued words plus a divider pass
    localparam int QUIET_LIMIT = 3000;
    localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

    // One expected rectangle
    typedef struct {
        logic [X_W-1:0]  x;
        logic [PIX_W-1:0] y;
        logic [PIX_W-1:0] w;
        logic [TS_W-1:0]  h;
        logic             last;
    } rect_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [WORD_BITS-1:0]  mask_word = '0;
    logic                  last_word = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [X_W-1:0]        rect_x;
    logic signed [PIX_W-1:0] rect_y;
    logic [PIX_W-1:0]      rect_width;
    logic [TS_W-1:0]       rect_height;
    logic                  last_of_word;

    // Shadow registers and scan state of the predictor
    int unsigned cfg_fw = FW_RESET;
    int unsigned cfg_fh = FH_RESET;
    int unsigned cfg_ts = TS_RESET;
    int unsigned scan_col = 0;
    int unsigned scan_row = 0;
    int unsigned run_first = 0;
    bit          run_live = 1'b0;
    bit          frame_over = 1'b0;

    rect_t rect_queue[$];
    int    errors = 0;
    int    words_sent = 0;
    int    burst_left = 0;
    int    quiet_cycles = 0;
    int    stall_mode = 0;
    int    stall_phase = 0;
    int    stall_run = 0;

    dirty_tile_run_rectangles_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mask_word   (mask_word),
        .last_word   (last_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .last_of_word(last_of_word)
    );

    always #5 clk = ~clk;

    // Tiles along one axis, rounded up and saturated
    function automatic int unsigned tiles_across(input int unsigned pixels,
                                                 input int unsigned ts);
        int unsigned n;
        n = (pixels + ts - 1) / ts;
        return (n > DIM_MAX) ? DIM_MAX : n;
    endfunction

    // Close the open run at end_col and queue its rectangle
    function automatic void close_run(input int unsigned ts, input int unsigned end_col);
        rect_t  r;
        longint prod;
        longint ypix;
        prod = longint'(run_first) * longint'(ts);
        r.x = prod[X_W-1:0];
        ypix = longint'(cfg_fh) - (longint'(scan_row) + 1) * longint'(ts);
        r.y = ypix[PIX_W-1:0];
        prod = longint'(end_col - run_first) * longint'(ts);
        r.w = prod[PIX_W-1:0];
        r.h = ts[TS_W-1:0];
        r.last = 1'b0;
        rect_queue.insert(rect_queue.size(), r);
        run_live = 1'b0;
    endfunction

    // Scan one accepted mask word, one tile flag per bit
    function automatic void scan_mask_word(input logic [WORD_BITS-1:0] w, input logic fin);
        int unsigned ts;
        int unsigned tx;
        int unsigned ty;
        int          n;
        logic        row_end;
        ts = (cfg_ts == 0) ? 1 : cfg_ts;
        tx = tiles_across(cfg_fw, ts);
        ty = tiles_across(cfg_fh, ts);
        n = 0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (frame_over || tx == 0 || ty == 0 || scan_row >= ty)
                continue;
            row_end = (scan_col + 1 >= tx);
            if (w[i]) begin
                if (!run_live) begin
                    run_live = 1'b1;
                    run_first = scan_col;
                end
                if (row_end) begin
                    close_run(ts, scan_col + 1);
                    n++;
                end
            end else if (run_live) begin
                close_run(ts, scan_col);
                n++;
            end
            if (row_end) begin
                scan_col = 0;
                scan_row = (scan_row + 1) & DIM_MAX;
                if (scan_row >= ty)
                    frame_over = 1'b1;
            end else begin
                scan_col = (scan_col + 1) & DIM_MAX;
            end
        end
        // last word: flush an open run and restart at tile (0,0)
        if (fin) begin
            if (run_live && n < 64) begin
                close_run(ts, scan_col);
                n++;
            end
            scan_col = 0;
            scan_row = 0;
            run_live = 1'b0;
            run_first = 0;
            frame_over = 1'b0;
        end
        if (n > 0)
            rect_queue[rect_queue.size() - 1].last = 1'b1;
    endfunction

    // Register write; entered and left at a falling edge
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        logic [CFG_DATA_W-1:0] data;
        data = val[CFG_DATA_W-1:0];
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_FRAME_WIDTH:  cfg_fw = data[FW_W-1:0];
            CFG_FRAME_HEIGHT: cfg_fh = data[FH_W-1:0];
            CFG_TILE_SIZE:    cfg_ts = data[TS_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_geometry(input int unsigned fw, input int unsigned fh,
                                input int unsigned ts);
        set_reg(CFG_FRAME_WIDTH, fw);
        set_reg(CFG_FRAME_HEIGHT, fh);
        set_reg(CFG_TILE_SIZE, ts);
    endtask

    // Drop valid, wait for every predicted rectangle, then let the scanner drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (rect_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One input transfer; bursts of random length separated by random gaps
    task automatic send_word(input logic [WORD_BITS-1:0] w, input logic fin);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1, 2:    gap = $urandom_range(1, 3);
                default: gap = $urandom_range(5, 20);
            endcase
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        mask_word <= w;
        last_word <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        scan_mask_word(w, fin);
        words_sent++;
        @(negedge clk);
    endtask

    // Reset geometry: 32 x 24 tiles, two rows per word
    task automatic test_default_frame();
        send_word(ALL_ONES, 1'b0);
        send_word('0, 1'b0);
        send_word(64'h5555_5555_5555_5555, 1'b0);
        send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_word(64'h8000_0000_0000_0001, 1'b1);
    endtask

    // Largest and smallest register values, zero tile size, empty frames
    task automatic test_config_extremes();
        wait_idle();
        set_geometry(16383, 16383, 1);
        send_word(64'h8000_0000_0000_0001, 1'b0);
        send_word(64'h1, 1'b0);
        send_word(ALL_ONES, 1'b1);
        wait_idle();
        set_geometry(16383, 1, 1024);
        send_word(ALL_ONES, 1'b0);
        send_word(ALL_ONES, 1'b1);
        wait_idle();
        set_geometry(5, 3, 0);
        send_word(64'h7FFF, 1'b1);
        wait_idle();
        set_geometry(16383, 16383, 16383);
        send_word(ALL_ONES, 1'b1);
        wait_idle();
        set_geometry(0, 768, 32);
        set_reg(CFG_SPARE, 5);
        send_word(ALL_ONES, 1'b1);
        wait_idle();
        set_geometry(1024, 0, 32);
        send_word(ALL_ONES, 1'b1);
    endtask

    // Words after the last tile are ignored until a last word
    task automatic test_frame_overrun();
        wait_idle();
        set_geometry(3, 2, 1);
        send_word(ALL_ONES, 1'b0);
        send_word(ALL_ONES, 1'b0);
        send_word(ALL_ONES, 1'b1);
        send_word(64'h3F, 1'b1);
    endtask

    // Geometry shrinks under open runs; only the last word closes the final one
    task automatic test_mid_frame_change();
        wait_idle();
        set_geometry(40, 10, 1);
        send_word(64'h8000_0000_0000_0000, 1'b0);
        wait_idle();
        set_reg(CFG_FRAME_WIDTH, 10);
        send_word(64'h8000_0000_0000_0003, 1'b0);
        wait_idle();
        set_reg(CFG_FRAME_HEIGHT, 2);
        send_word('0, 1'b0);
        send_word('0, 1'b1);
    endtask

    // Random geometry, mostly whole frames with random masks, some broken ones
    task automatic test_random_frames();
        int unsigned ts;
        int unsigned tx;
        int unsigned ty;
        int          start;
        int          frame_words;
        int          last_at;
        int          pos;
        int          len;
        logic        fill;
        logic [WORD_BITS-1:0] m;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            wait_idle();
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 4))
                    0:       ts = 0;
                    1:       ts = 1;
                    2:       ts = 1024;
                    3:       ts = 2047;
                    default: ts = $urandom_range(1, 2047);
                endcase
                set_geometry($urandom_range(0, 16383), $urandom_range(0, 16383), ts);
            end else begin
                ts = $urandom_range(1, 64);
                tx = $urandom_range(1, 40);
                ty = $urandom_range(1, 12);
                set_geometry((tx - 1) * ts + $urandom_range(1, ts),
                             (ty - 1) * ts + $urandom_range(1, ts), ts);
            end
            ts = (cfg_ts == 0) ? 1 : cfg_ts;
            tx = tiles_across(cfg_fw, ts);
            ty = tiles_across(cfg_fh, ts);
            repeat ($urandom_range(1, 4)) begin
                frame_words = (tx * ty + WORD_BITS - 1) / WORD_BITS;
                if (frame_words == 0)
                    frame_words = $urandom_range(1, 2);
                if (frame_words > 6)
                    frame_words = 6;
                last_at = frame_words - 1;
                // broken frame: odd length, last flag early, late or missing
                if ($urandom_range(0, 6) == 0) begin
                    frame_words = $urandom_range(1, frame_words + 2);
                    last_at = $urandom_range(0, frame_words);
                end
                for (int k = 0; k < frame_words; k++) begin
                    case ($urandom_range(0, 6))
                        0:       m = ALL_ONES;
                        1:       m = '0;
                        2:       m = {$urandom, $urandom} & {$urandom, $urandom}
                                     & {$urandom, $urandom};
                        3:       m = {$urandom, $urandom} | {$urandom, $urandom};
                        4, 5:
                        begin
                            pos = 0;
                            fill = $urandom_range(0, 1);
                            while (pos < WORD_BITS) begin
                                len = $urandom_range(1, 10);
                                for (int j = 0; j < len && pos < WORD_BITS; j++) begin
                                    m[pos] = fill;
                                    pos++;
                                end
                                fill = !fill;
                            end
                        end
                        default: m = {$urandom, $urandom};
                    endcase
                    send_word(m, k == last_at);
                end
            end
        end
    endtask

    // Receiver stall pattern: none, scattered, or long runs, changing over time
    always @(negedge clk) begin
        if (stall_phase == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_phase = 300;
        end
        stall_phase--;
        if (stall_run > 0) begin
            stall_run--;
            out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    if ($urandom_range(0, 3) == 0) begin
                        stall_run = $urandom_range(0, 11);
                        out_stall <= 1'b1;
                    end else begin
                        out_stall <= 1'b0;
                    end
                end
            endcase
        end
    end

    // Compare each output transfer with the oldest predicted rectangle
    always @(posedge clk) begin : check_rects
        rect_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (rect_queue.size() == 0) begin
                $error("unexpected rectangle x=%0d y=%0d w=%0d h=%0d", rect_x,
                       rect_y, rect_width, rect_height);
                errors++;
            end else begin
                want = rect_queue.pop_front();
                if (rect_x !== want.x) begin
                    $error("rect_x: expected %0d, got %0d", want.x, rect_x);
                    errors++;
                end
                if (rect_y !== want.y) begin
                    $error("rect_y: expected %0d, got %0d", $signed(want.y), rect_y);
                    errors++;
                end
                if (rect_width !== want.w) begin
                    $error("rect_width: expected %0d, got %0d", want.w, rect_width);
                    errors++;
                end
                if (rect_height !== want.h) begin
                    $error("rect_height: expected %0d, got %0d", want.h, rect_height);
                    errors++;
                end
                if (last_of_word !== want.last) begin
                    $error("last_of_word: expected %0d, got %0d", want.last, last_of_word);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long without any transfer
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $error("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // Test sequence
    initial begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_default_frame();
        test_config_extremes();
        test_frame_overrun();
        test_mid_frame_change();
        test_random_frames();
        wait_idle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== dirty_tile_run_rectangles_unit.f =====
src/dtr_pkg.sv
src/dtr_div.sv
src/dtr_front.sv
src/dtr_back.sv
src/dirty_tile_run_rectangles_unit.sv
sim/testbench.sv
